// ===== rtl/acpe_pkg.sv =====
// ----------------------------------------------------------------------------
// acpe_pkg
// Shared types, constants and helpers of the access code payload extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package acpe_pkg;

   // default sizes of the code and payload sections of the bit window
   localparam int DEF_MAX_PREAMBLE_BITS = 64;
   localparam int DEF_MAX_PAYLOAD_BITS  = 64;

   // fixed field widths
   localparam int LEN_W       = 7;
   localparam int PATTERN_W   = 64;
   localparam int PAYLOAD_W   = 64;
   localparam int REQ_DATA_W  = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int SPAN_W      = LEN_W + 1;
   localparam int GRP_CNT_W   = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE_PATTERN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE_LENGTH  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PAYLOAD_LENGTH   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_MISMATCHES   = 8'd3;

   // register reset values
   localparam logic [PATTERN_W-1:0] RST_PREAMBLE_PATTERN = 64'd0;
   localparam logic [LEN_W-1:0]     RST_PREAMBLE_LENGTH  = 7'd32;
   localparam logic [LEN_W-1:0]     RST_PAYLOAD_LENGTH   = 7'd64;
   localparam logic [LEN_W-1:0]     RST_MAX_MISMATCHES   = 7'd0;

   // effective settings, lengths already clamped to their legal range
   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [LEN_W-1:0]     code_len;
      logic [LEN_W-1:0]     pay_len;
      logic [LEN_W-1:0]     max_mis;
   } settings_type;

   // zero reads as one, anything above the limit reads as the limit
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] maxv);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // ones count of one byte
   function automatic logic [GRP_CNT_W-1:0] popcount8(input logic [7:0] v);
      logic [GRP_CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + GRP_CNT_W'(v[i]);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/acpe_csr.sv =====
// ----------------------------------------------------------------------------
// acpe_csr
// Configuration registers with length clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module acpe_csr #(
   parameter int MAX_PREAMBLE_BITS = acpe_pkg::DEF_MAX_PREAMBLE_BITS,
   parameter int MAX_PAYLOAD_BITS  = acpe_pkg::DEF_MAX_PAYLOAD_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [acpe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [acpe_pkg::CSR_DATA_W-1:0]    csr_data,
   output acpe_pkg::settings_type                  settings
);

   logic [acpe_pkg::PATTERN_W-1:0] pattern_ff;
   logic [acpe_pkg::LEN_W-1:0]     pre_len_ff;
   logic [acpe_pkg::LEN_W-1:0]     pay_len_ff;
   logic [acpe_pkg::LEN_W-1:0]     max_mis_ff;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register file, unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= acpe_pkg::RST_PREAMBLE_PATTERN;
         pre_len_ff <= acpe_pkg::RST_PREAMBLE_LENGTH;
         pay_len_ff <= acpe_pkg::RST_PAYLOAD_LENGTH;
         max_mis_ff <= acpe_pkg::RST_MAX_MISMATCHES;
      end else if (csr_valid) begin
         unique case (csr_index)
            acpe_pkg::REG_PREAMBLE_PATTERN: begin
               pattern_ff <= csr_data[acpe_pkg::PATTERN_W-1:0];
            end
            acpe_pkg::REG_PREAMBLE_LENGTH: begin
               pre_len_ff <= csr_data[acpe_pkg::LEN_W-1:0];
            end
            acpe_pkg::REG_PAYLOAD_LENGTH: begin
               pay_len_ff <= csr_data[acpe_pkg::LEN_W-1:0];
            end
            acpe_pkg::REG_MAX_MISMATCHES: begin
               max_mis_ff <= csr_data[acpe_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective settings
   always_comb begin
      settings.pattern  = pattern_ff;
      settings.code_len = acpe_pkg::clamp_len(pre_len_ff,
                                              acpe_pkg::LEN_W'(MAX_PREAMBLE_BITS));
      settings.pay_len  = acpe_pkg::clamp_len(pay_len_ff,
                                              acpe_pkg::LEN_W'(MAX_PAYLOAD_BITS));
      settings.max_mis  = max_mis_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/access_code_payload_extractor_core.sv =====
// ----------------------------------------------------------------------------
// access_code_payload_extractor_core
// Sliding-window access code correlator with mismatch tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received hard bit per request in req_tdata[0]. Every
//   request shifts the bit window; once enough bits have arrived, the oldest
//   code bits of the span are compared with the programmed access code, and
//   when the mismatch count is within max_mismatches one response carries the
//   payload bits that follow the code, first received bit in bit 0.
//   csr_* writes one register per request (index 0 pattern, 1 code length,
//   2 payload length, 3 mismatch allowance); csr_ready is always high.
// Throughput: one request per cycle unless the stages are stalled (see Stall).
// Pipeline: a response passes through the stage registers in order (the
//   window loads at the accepting edge, then code/payload shift, code
//   alignment and xor, byte ones count, sum and compare into the output
//   register).
// Stall: each stage holds while the one after it is full and held; a
//   stalled response waits in the output register and bubbles still close
//   up, so req_tready drops only when every stage holds an item.
// Reset: window, fill count and stage valids clear; registers
//   return to code 0, code length 32, payload length 64, allowance 0.
// ----------------------------------------------------------------------------
`default_nettype none

module access_code_payload_extractor_core #(
   parameter int MAX_PREAMBLE_BITS = acpe_pkg::DEF_MAX_PREAMBLE_BITS,
   parameter int MAX_PAYLOAD_BITS  = acpe_pkg::DEF_MAX_PAYLOAD_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [acpe_pkg::REQ_DATA_W-1:0]    req_tdata,   // [0] in_bit
   // response channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [acpe_pkg::PAYLOAD_W-1:0]          rsp_tdata,   // [63:0] payload_bits
   // configuration channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [acpe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [acpe_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int WIN_BITS = MAX_PREAMBLE_BITS + MAX_PAYLOAD_BITS;
   localparam int FILL_W   = $clog2(WIN_BITS + 1);
   localparam int NGRP     = (MAX_PREAMBLE_BITS + 7) / 8;
   localparam int GRP_PAD  = NGRP * 8;

   acpe_pkg::settings_type settings;

   acpe_csr #(
      .MAX_PREAMBLE_BITS (MAX_PREAMBLE_BITS),
      .MAX_PAYLOAD_BITS  (MAX_PAYLOAD_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .settings  (settings)
   );

   // window state
   logic [WIN_BITS-1:0] win_ff;
   logic [WIN_BITS-1:0] win_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic [acpe_pkg::SPAN_W-1:0] span;
   logic                full;

   // stage registers
   logic                          s1_v_ff;
   logic [WIN_BITS-1:0]           s1_win_ff;
   logic                          s2_v_ff;
   logic [MAX_PREAMBLE_BITS-1:0]  s2_code_ff;
   logic [MAX_PAYLOAD_BITS-1:0]   s2_pay_ff;
   logic                          s3_v_ff;
   logic [MAX_PREAMBLE_BITS-1:0]  s3_diff_ff;
   logic [MAX_PAYLOAD_BITS-1:0]   s3_pay_ff;
   logic                          s4_v_ff;
   logic [acpe_pkg::GRP_CNT_W-1:0] s4_grp_ff [NGRP];
   logic [MAX_PAYLOAD_BITS-1:0]   s4_pay_ff;
   logic                          rsp_valid_ff;
   logic [acpe_pkg::PAYLOAD_W-1:0] rsp_data_ff;

   // stage next values
   logic [WIN_BITS-1:0]           code_shift;
   logic [MAX_PREAMBLE_BITS-1:0]  code_rev;
   logic [MAX_PAYLOAD_BITS-1:0]   pay_rev;
   logic [MAX_PAYLOAD_BITS-1:0]   s2_pay_in;
   logic [acpe_pkg::LEN_W-1:0]    code_gap;
   logic [acpe_pkg::LEN_W-1:0]    pay_gap;
   logic [MAX_PREAMBLE_BITS-1:0]  code_aligned;
   logic [MAX_PREAMBLE_BITS-1:0]  code_mask;
   logic [MAX_PREAMBLE_BITS-1:0]  s3_diff_in;
   logic [GRP_PAD-1:0]            diff_pad;
   logic [acpe_pkg::GRP_CNT_W-1:0] s4_grp_in [NGRP];
   logic [acpe_pkg::LEN_W-1:0]    mis_sum;
   logic                          hit;

   // flow control
   logic req_fire;
   logic out_free;
   logic s4_move, s4_take;
   logic s3_move, s3_take;
   logic s2_move, s2_take;
   logic s1_move, s1_take;

   // each stage moves on when the next one is empty or moving
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      s4_move    = s4_v_ff && out_free;
      s4_take    = !s4_v_ff || s4_move;
      s3_move    = s3_v_ff && s4_take;
      s3_take    = !s3_v_ff || s3_move;
      s2_move    = s2_v_ff && s3_take;
      s2_take    = !s2_v_ff || s2_move;
      s1_move    = s1_v_ff && s2_take;
      s1_take    = !s1_v_ff || s1_move;
      req_tready = s1_take;
      req_fire   = req_tvalid && req_tready;
   end

   // window shift, saturating fill count and span check
   always_comb begin
      win_in  = {win_ff[WIN_BITS-2:0], req_tdata[0]};
      fill_in = (fill_ff != FILL_W'(WIN_BITS)) ? fill_ff + FILL_W'(1) : fill_ff;
      span    = {1'b0, settings.code_len} + {1'b0, settings.pay_len};
      full    = acpe_pkg::SPAN_W'(fill_in) >= span;
   end

   // code section moved down to bit 0 and reversed; payload reversed and
   // aligned so the first received payload bit lands in bit 0
   always_comb begin
      code_shift = s1_win_ff >> settings.pay_len;
      for (int i = 0; i < MAX_PREAMBLE_BITS; i++) begin
         code_rev[MAX_PREAMBLE_BITS-1-i] = code_shift[i];
      end
      for (int i = 0; i < MAX_PAYLOAD_BITS; i++) begin
         pay_rev[MAX_PAYLOAD_BITS-1-i] = s1_win_ff[i];
      end
      pay_gap   = acpe_pkg::LEN_W'(MAX_PAYLOAD_BITS) - settings.pay_len;
      s2_pay_in = pay_rev >> pay_gap;
   end

   // align code bit k to pattern bit k and mark differing bits
   always_comb begin
      code_gap     = acpe_pkg::LEN_W'(MAX_PREAMBLE_BITS) - settings.code_len;
      code_aligned = s2_code_ff >> code_gap;
      code_mask    = {MAX_PREAMBLE_BITS{1'b1}} >> code_gap;
      s3_diff_in   = (code_aligned ^ settings.pattern[MAX_PREAMBLE_BITS-1:0]) & code_mask;
   end

   // ones count per byte of the difference vector
   always_comb begin
      diff_pad = GRP_PAD'(s3_diff_ff);
      for (int g = 0; g < NGRP; g++) begin
         s4_grp_in[g] = acpe_pkg::popcount8(diff_pad[g*8 +: 8]);
      end
   end

   // total mismatches against the allowance
   always_comb begin
      mis_sum = '0;
      for (int g = 0; g < NGRP; g++) begin
         mis_sum = mis_sum + acpe_pkg::LEN_W'(s4_grp_ff[g]);
      end
      hit = mis_sum <= settings.max_mis;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         fill_ff      <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            win_ff  <= win_in;
            fill_ff <= fill_in;
         end
         if (s1_take) begin
            s1_v_ff <= req_fire && full;
         end
         if (s2_take) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_take) begin
            s3_v_ff <= s2_v_ff;
         end
         if (s4_take) begin
            s4_v_ff <= s3_v_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s4_move && hit;
         end
      end
   end

   // payload of the stages
   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_win_ff <= win_in;
      end
      if (s2_take) begin
         s2_code_ff <= code_rev;
         s2_pay_ff  <= s2_pay_in;
      end
      if (s3_take) begin
         s3_diff_ff <= s3_diff_in;
         s3_pay_ff  <= s2_pay_ff;
      end
      if (s4_take) begin
         s4_grp_ff <= s4_grp_in;
         s4_pay_ff <= s3_pay_ff;
      end
      if (s4_move && hit) begin
         rsp_data_ff <= acpe_pkg::PAYLOAD_W'(s4_pay_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // fill count never passes the window size
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_BITS))
      else $error("fill count beyond window size");

   // a saturated fill count stays saturated
   assert property (@(posedge clock) disable iff (reset)
      fill_ff == FILL_W'(WIN_BITS) |=> fill_ff == FILL_W'(WIN_BITS))
      else $error("saturated fill count dropped");

   // an item in the last stage is held while the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      s4_v_ff && !out_free |=> s4_v_ff)
      else $error("last stage item lost under stall");

   // a response only appears from an item in the last stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s4_v_ff))
      else $error("response without a source item");

endmodule

`default_nettype wire
